/* rtl/kmm_pkg.sv */
// kmm_pkg: shared constants, request and status codes, and controller/datapath
// command and status structs for the keyed mutex manager.
// No dependencies.
`timescale 1ns / 1ps

package kmm_pkg;

    // Default table geometry
    localparam int LOCK_COUNT_DEF = 16;
    localparam int WAIT_DEPTH_DEF = 16;

    // Request modes
    localparam logic [1:0] MODE_OPEN    = 2'd0;
    localparam logic [1:0] MODE_ACQUIRE = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OPENED    = 3'd0;
    localparam logic [2:0] ST_GRANTED   = 3'd1;
    localparam logic [2:0] ST_QUEUED    = 3'd2;
    localparam logic [2:0] ST_HANDED    = 3'd3;
    localparam logic [2:0] ST_UNLOCKED  = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_NOT_OWNER = 3'd6;
    localparam logic [2:0] ST_QFULL     = 3'd7;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;      // latch the accepted transaction
        logic walk_issue;   // step the key search
        logic open_finish;  // commit the open outcome
        logic exec;         // acquire/release decision and commit
        logic hand_finish;  // commit hand-off to the oldest waiter
        logic load_out;     // move the result into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic in_open;      // incoming transaction is an open
        logic walk_hit;     // live entry with matching key found
        logic walk_end;     // last entry compared without a match
        logic need_hand;    // release needs a waiter read
        logic out_free;     // output register can take a result
    } t_stat;

endpackage

/* rtl/kmm_ctrl.sv */
// kmm_ctrl: sequencing state machine for the keyed mutex manager.
// Depends on kmm_pkg (t_cmd, t_stat).
`timescale 1ns / 1ps

module kmm_ctrl
    import kmm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_WALK     = 3'd1;
    localparam logic [2:0] S_OPEN_FIN = 3'd2;
    localparam logic [2:0] S_EXEC     = 3'd3;
    localparam logic [2:0] S_HAND     = 3'd4;
    localparam logic [2:0] S_OUT      = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_stat.in_open ? S_WALK : S_EXEC;
                end
            end
            S_WALK: begin
                o_cmd.walk_issue = 1'b1;
                if (i_stat.walk_hit || i_stat.walk_end) begin
                    n_state = S_OPEN_FIN;
                end
            end
            S_OPEN_FIN: begin
                o_cmd.open_finish = 1'b1;
                n_state = S_OUT;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = i_stat.need_hand ? S_HAND : S_OUT;
            end
            S_HAND: begin
                o_cmd.hand_finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Accepted transaction always starts a search or an execute step
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_WALK || r_state == S_EXEC))
        else $error("accepted transaction did not dispatch");

    // Result handed to the output register returns the controller to idle
    a_out_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_stat.out_free) |=> (r_state == S_IDLE))
        else $error("result load did not return to idle");

    // Hand-off step only follows an execute step
    a_hand_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HAND) |-> ($past(r_state) == S_EXEC))
        else $error("hand-off step without preceding execute");

endmodule

/* rtl/kmm_dpath.sv */
// kmm_dpath: mutex table, key store, waiter queues and result registers.
// Depends on kmm_pkg (codes, t_cmd, t_stat).
`timescale 1ns / 1ps

module kmm_dpath
    import kmm_pkg::*;
#(
    parameter int LOCK_COUNT = LOCK_COUNT_DEF,
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_lock_key,
    input  logic [3:0]         i_lock_index,
    input  logic [7:0]         i_requester_pid,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic [3:0]         o_result_index,
    output logic [7:0]         o_woken_pid
);

    localparam int IDX_W  = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
    localparam int WLK_W  = IDX_W + 1;
    localparam int HEAD_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WAIT_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int WQ_N   = LOCK_COUNT * WAIT_DEPTH;
    localparam int ADDR_W = (WQ_N > 1) ? $clog2(WQ_N) : 1;

    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WAIT_DEPTH);
    localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(WAIT_DEPTH - 1);
    localparam logic [SUM_W-1:0]  SUM_WRAP  = SUM_W'(WAIT_DEPTH);
    localparam logic [WLK_W-1:0]  WLK_END   = WLK_W'(LOCK_COUNT);
    localparam logic [WLK_W-1:0]  WLK_LAST  = WLK_W'(LOCK_COUNT - 1);
    localparam logic [ADDR_W-1:0] WQ_STRIDE = ADDR_W'(WAIT_DEPTH);

    // Per-entry table state
    logic [7:0]        r_hc     [LOCK_COUNT];
    logic              r_locked [LOCK_COUNT];
    logic [7:0]        r_owner  [LOCK_COUNT];
    logic [HEAD_W-1:0] r_head   [LOCK_COUNT];
    logic [CNT_W-1:0]  r_wcnt   [LOCK_COUNT];

    // Key store and waiter store
    logic [31:0] key_mem [LOCK_COUNT];
    logic [7:0]  wq_mem  [WQ_N];

    // Captured transaction
    logic [1:0]       r_mode;
    logic [31:0]      r_key;
    logic [3:0]       r_lock_index;
    logic [IDX_W-1:0] r_idx;
    logic             r_bad;
    logic [7:0]       r_pid;

    // Key search pipeline
    logic [WLK_W-1:0] r_issue;
    logic             r_cmp_vld;
    logic             r_cmp_live;
    logic             r_cmp_last;
    logic [IDX_W-1:0] r_cmp_idx;
    logic [31:0]      r_key_q;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;

    // Result and output registers
    logic [7:0] r_wq_q;
    logic [2:0] r_res_status;
    logic [3:0] r_res_idx;
    logic [7:0] r_res_woken;
    logic       r_o_valid;
    logic [2:0] r_o_status;
    logic [3:0] r_o_idx;
    logic [7:0] r_o_woken;

    logic [8:0]        in_idx_wide;
    logic [IDX_W-1:0]  issue_addr;
    logic              issue_live;
    logic              issue_en;
    logic              walk_hit;
    logic              walk_end;
    logic [IDX_W-1:0]  open_idx;
    logic [8:0]        open_idx_wide;
    logic              cur_locked;
    logic [7:0]        cur_owner;
    logic [HEAD_W-1:0] cur_head;
    logic [CNT_W-1:0]  cur_cnt;
    logic [SUM_W-1:0]  tail_sum;
    logic [SUM_W-1:0]  tail_wrap;
    logic [HEAD_W-1:0] tail_slot;
    logic [HEAD_W-1:0] head_next;
    logic [ADDR_W-1:0] wq_base;
    logic [ADDR_W-1:0] wq_waddr;
    logic [ADDR_W-1:0] wq_raddr;
    logic              wq_we;
    logic              wq_re;
    logic [2:0]        ex_status;
    logic              ex_grant;
    logic              ex_queue;
    logic              ex_unlock;
    logic              need_hand;
    logic              out_free;

    // Input index decode
    assign in_idx_wide = 9'(i_lock_index);

    // Key search: issue one entry a cycle, compare it the next
    assign issue_addr = r_issue[IDX_W-1:0];
    assign issue_live = (r_issue < WLK_END);
    assign walk_hit   = r_cmp_vld && r_cmp_live && (r_key_q == r_key);
    assign walk_end   = r_cmp_vld && r_cmp_last && !walk_hit;
    assign issue_en   = i_cmd.walk_issue && !walk_hit && !walk_end;

    assign open_idx      = walk_hit ? r_cmp_idx : r_free_idx;
    assign open_idx_wide = 9'(open_idx);

    // Selected entry for acquire and release
    assign cur_locked = r_locked[r_idx];
    assign cur_owner  = r_owner[r_idx];
    assign cur_head   = r_head[r_idx];
    assign cur_cnt    = r_wcnt[r_idx];

    // Circular queue slots
    assign tail_sum  = SUM_W'(cur_head) + SUM_W'(cur_cnt);
    assign tail_wrap = (tail_sum >= SUM_WRAP) ? (tail_sum - SUM_WRAP) : tail_sum;
    assign tail_slot = tail_wrap[HEAD_W-1:0];
    assign head_next = (cur_head == HEAD_LAST) ? '0 : (cur_head + 1'b1);
    assign wq_base   = ADDR_W'(r_idx) * WQ_STRIDE;
    assign wq_waddr  = wq_base + ADDR_W'(tail_slot);
    assign wq_raddr  = wq_base + ADDR_W'(cur_head);

    // Acquire / release decision
    always_comb begin
        ex_status = ST_NOT_OWNER;
        ex_grant  = 1'b0;
        ex_queue  = 1'b0;
        ex_unlock = 1'b0;
        need_hand = 1'b0;
        if (!r_bad) begin
            case (r_mode)
                MODE_ACQUIRE: begin
                    if (!cur_locked) begin
                        ex_grant  = 1'b1;
                        ex_status = ST_GRANTED;
                    end else if (cur_cnt == CNT_FULL) begin
                        ex_status = ST_QFULL;
                    end else begin
                        ex_queue  = 1'b1;
                        ex_status = ST_QUEUED;
                    end
                end
                MODE_RELEASE: begin
                    if (cur_locked && (cur_owner == r_pid)) begin
                        if (cur_cnt != '0) begin
                            need_hand = 1'b1;
                            ex_status = ST_HANDED;
                        end else begin
                            ex_unlock = 1'b1;
                            ex_status = ST_UNLOCKED;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign wq_we = i_cmd.exec && ex_queue;
    assign wq_re = i_cmd.exec && need_hand;

    assign out_free = !r_o_valid || !i_stall;

    // Status to controller
    always_comb begin
        o_stat           = '0;
        o_stat.in_open   = (i_mode == MODE_OPEN);
        o_stat.walk_hit  = walk_hit;
        o_stat.walk_end  = walk_end;
        o_stat.need_hand = need_hand;
        o_stat.out_free  = out_free;
    end

    // Transaction capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode       <= i_mode;
            r_key        <= i_lock_key;
            r_lock_index <= i_lock_index;
            r_idx        <= in_idx_wide[IDX_W-1:0];
            r_bad        <= (in_idx_wide >= 9'(LOCK_COUNT));
            r_pid        <= i_requester_pid;
        end
    end

    // Key search control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue      <= '0;
            r_cmp_vld    <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.capture) begin
            r_issue      <= '0;
            r_cmp_vld    <= 1'b0;
            r_free_found <= 1'b0;
        end else if (issue_en) begin
            r_cmp_vld <= issue_live;
            if (issue_live) begin
                r_issue <= r_issue + 1'b1;
                if (r_hc[issue_addr] == 8'd0 && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end
        end
    end

    // Key search payload
    always_ff @(posedge i_clk) begin
        if (issue_en && issue_live) begin
            r_cmp_idx  <= issue_addr;
            r_cmp_live <= (r_hc[issue_addr] != 8'd0);
            r_cmp_last <= (r_issue == WLK_LAST);
            if (r_hc[issue_addr] == 8'd0 && !r_free_found) begin
                r_free_idx <= issue_addr;
            end
        end
    end

    // Key store: claim write, search read
    always_ff @(posedge i_clk) begin
        if (i_cmd.open_finish && !walk_hit && r_free_found) begin
            key_mem[r_free_idx] <= r_key;
        end
        if (issue_en && issue_live) begin
            r_key_q <= key_mem[issue_addr];
        end
    end

    // Waiter store: enqueue write, hand-off read
    always_ff @(posedge i_clk) begin
        if (wq_we) begin
            wq_mem[wq_waddr] <= r_pid;
        end
        if (wq_re) begin
            r_wq_q <= wq_mem[wq_raddr];
        end
    end

    // Mutex table updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LOCK_COUNT; j++) begin
                r_hc[j]     <= '0;
                r_locked[j] <= 1'b0;
                r_owner[j]  <= '0;
                r_head[j]   <= '0;
                r_wcnt[j]   <= '0;
            end
        end else begin
            if (i_cmd.open_finish) begin
                if (walk_hit) begin
                    if (r_hc[r_cmp_idx] != 8'hff) begin
                        r_hc[r_cmp_idx] <= r_hc[r_cmp_idx] + 8'd1;
                    end
                end else if (r_free_found) begin
                    r_hc[r_free_idx] <= 8'd1;
                end
            end
            if (i_cmd.exec) begin
                if (ex_grant) begin
                    r_locked[r_idx] <= 1'b1;
                    r_owner[r_idx]  <= r_pid;
                end
                if (ex_queue) begin
                    r_wcnt[r_idx] <= cur_cnt + 1'b1;
                end
                if (ex_unlock) begin
                    r_locked[r_idx] <= 1'b0;
                    r_owner[r_idx]  <= '0;
                end
            end
            if (i_cmd.hand_finish) begin
                r_owner[r_idx] <= r_wq_q;
                r_head[r_idx]  <= head_next;
                r_wcnt[r_idx]  <= cur_cnt - 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.open_finish) begin
            r_res_woken <= '0;
            if (walk_hit || r_free_found) begin
                r_res_status <= ST_OPENED;
                r_res_idx    <= open_idx_wide[3:0];
            end else begin
                r_res_status <= ST_FULL;
                r_res_idx    <= '0;
            end
        end else if (i_cmd.exec && !need_hand) begin
            r_res_status <= ex_status;
            r_res_idx    <= r_lock_index;
            r_res_woken  <= '0;
        end else if (i_cmd.hand_finish) begin
            r_res_status <= ST_HANDED;
            r_res_idx    <= r_lock_index;
            r_res_woken  <= r_wq_q;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_status <= r_res_status;
            r_o_idx    <= r_res_idx;
            r_o_woken  <= r_res_woken;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_result_index = r_o_idx;
    assign o_woken_pid    = r_o_woken;

    // Enqueue never targets a full waiter queue
    a_no_enq_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wq_we |-> (cur_cnt != CNT_FULL))
        else $error("enqueue into full waiter queue");

    // Hand-off result reports the waiter read from the store
    a_hand_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hand_finish |=> (r_res_status == ST_HANDED && r_res_woken == $past(r_wq_q)))
        else $error("hand-off result mismatch");

    // Open with no match and no free entry reports a full table
    a_open_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.open_finish && !walk_hit && !r_free_found) |=> (r_res_status == ST_FULL))
        else $error("full table not reported");

endmodule

/* rtl/keyed_mutex_manager_unit.sv */
// keyed_mutex_manager_unit: top level, controller plus datapath (kmm_ctrl, kmm_dpath, kmm_pkg).
// Open: the key search reads one table entry per cycle and ends at the first live entry whose
//   key matches, else after the last entry; the open outcome is then committed and loaded.
// Acquire, release, bad requests: an execute step; hand-off release adds a waiter store read.
// One transaction at a time; the next is accepted the cycle after a result is loaded.
// Reset (i_rst_n low, synchronous) clears the per-entry table state and drops o_valid.
`timescale 1ns / 1ps

module keyed_mutex_manager_unit
    import kmm_pkg::*;
#(
    parameter int LOCK_COUNT = LOCK_COUNT_DEF,
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_lock_key,
    input  logic [3:0]         i_lock_index,
    input  logic [7:0]         i_requester_pid,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic [3:0]         o_result_index,
    output logic [7:0]         o_woken_pid
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    kmm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Table and result datapath
    kmm_dpath #(
        .LOCK_COUNT (LOCK_COUNT),
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_mode          (i_mode),
        .i_lock_key      (i_lock_key),
        .i_lock_index    (i_lock_index),
        .i_requester_pid (i_requester_pid),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_result_index  (o_result_index),
        .o_woken_pid     (o_woken_pid)
    );

endmodule

/* tb/keyed_mutex_manager_unit_test.sv */
// keyed_mutex_manager_unit_test: self-checking bench for the keyed mutex manager.
// Runs a directed table, then random lock sequences, scored against script values or an in-bench model.
// Depends on kmm_pkg and keyed_mutex_manager_unit.
`timescale 1ns / 1ps

module keyed_mutex_manager_unit_test;
    import kmm_pkg::*;

    localparam int         LOCKS      = LOCK_COUNT_DEF;
    localparam int         DEPTH      = WAIT_DEPTH_DEF;
    localparam logic [1:0] MODE_UNDEF = 2'd3;
    localparam int         RAND_ITEMS = 900;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] index;
        logic [7:0] woken;
    } t_result;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [3:0]  idx;
        logic [7:0]  pid;
        logic        known;
        t_result     want;
    } t_script_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_mode = MODE_OPEN;
    logic signed [31:0] i_lock_key = '0;
    logic [3:0]         i_lock_index = '0;
    logic [7:0]         i_requester_pid = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [2:0]         o_status;
    logic [3:0]         o_result_index;
    logic [7:0]         o_woken_pid;

    // mutex table as the bench sees it
    logic [31:0] mx_key      [LOCKS];
    logic [7:0]  mx_handles  [LOCKS];
    logic        mx_locked   [LOCKS];
    logic [7:0]  mx_owner    [LOCKS];
    logic [7:0]  mx_waiters  [LOCKS][DEPTH];
    logic [3:0]  mx_head     [LOCKS];
    logic [4:0]  mx_wait_len [LOCKS];

    t_result     pending_results [$];
    int unsigned requests_sent;
    int unsigned results_checked;
    int unsigned failures;
    int unsigned status_tally [8];
    logic        quiet = 1'b0;
    t_result     head_result;

    keyed_mutex_manager_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_lock_key      (i_lock_key),
        .i_lock_index    (i_lock_index),
        .i_requester_pid (i_requester_pid),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_result_index  (o_result_index),
        .o_woken_pid     (o_woken_pid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #(5_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // apply one request to the bench's table and return the outcome it must produce
    function automatic t_result mutex_outcome(input logic [1:0] mode, input logic [31:0] key,
                                              input logic [3:0] idx, input logic [7:0] pid);
        t_result r;
        int      hit;
        int      free_slot;
        r = '{status: ST_NOT_OWNER, index: idx, woken: 8'h00};
        case (mode)
            MODE_OPEN: begin
                hit = -1;
                free_slot = -1;
                for (int i = LOCKS - 1; i >= 0; i--) begin
                    if (mx_handles[i] != 0 && mx_key[i] == key) hit = i;
                    if (mx_handles[i] == 0) free_slot = i;
                end
                if (hit >= 0) begin
                    if (mx_handles[hit] != 8'hFF) mx_handles[hit]++;
                    r = '{status: ST_OPENED, index: 4'(hit), woken: 8'h00};
                end else if (free_slot >= 0) begin
                    mx_handles[free_slot] = 8'd1;
                    mx_key[free_slot] = key;
                    r = '{status: ST_OPENED, index: 4'(free_slot), woken: 8'h00};
                end else begin
                    r = '{status: ST_FULL, index: 4'd0, woken: 8'h00};
                end
            end
            MODE_ACQUIRE: begin
                if (!mx_locked[idx]) begin
                    mx_locked[idx] = 1'b1;
                    mx_owner[idx] = pid;
                    r.status = ST_GRANTED;
                end else if (mx_wait_len[idx] >= DEPTH) begin
                    r.status = ST_QFULL;
                end else begin
                    mx_waiters[idx][4'(mx_head[idx] + mx_wait_len[idx])] = pid;
                    mx_wait_len[idx]++;
                    r.status = ST_QUEUED;
                end
            end
            MODE_RELEASE: begin
                if (mx_locked[idx] && mx_owner[idx] == pid) begin
                    if (mx_wait_len[idx] != 0) begin
                        r.woken = mx_waiters[idx][mx_head[idx]];
                        mx_head[idx]++;
                        mx_wait_len[idx]--;
                        mx_owner[idx] = r.woken;
                        r.status = ST_HANDED;
                    end else begin
                        mx_owner[idx] = 8'h00;
                        mx_locked[idx] = 1'b0;
                        r.status = ST_UNLOCKED;
                    end
                end
            end
            default: ;  // undefined mode: flagged, table untouched
        endcase
        return r;
    endfunction

    // drive one transaction, wait for acceptance, then queue what it must produce
    task automatic issue_request(input logic [1:0] mode, input logic [31:0] key,
                                 input logic [3:0] idx, input logic [7:0] pid,
                                 input logic known, input t_result want);
        t_result pred;
        quiet <= (requests_sent >= 450 && requests_sent < 600);
        while (!quiet && $urandom_range(0, 99) < 28) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_mode          <= mode;
        i_lock_key      <= key;
        i_lock_index    <= idx;
        i_requester_pid <= pid;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pred = mutex_outcome(mode, key, idx, pid);
        pending_results.push_back(known ? want : pred);
        requests_sent++;
    endtask

    task automatic issue_random(input logic [1:0] mode, input logic [31:0] key,
                                input logic [3:0] idx, input logic [7:0] pid);
        issue_request(mode, key, idx, pid, 1'b0, '0);
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= (i_rst_n && !quiet) ? ($urandom_range(0, 99) < 28) : 1'b0;
    end

    // result scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_checked++;
            status_tally[o_status]++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: status %0d index %0d woken %0d",
                         $time, o_status, o_result_index, o_woken_pid);
                failures++;
            end else begin
                head_result = pending_results.pop_front();
                if (o_status !== head_result.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, head_result.status, o_status);
                    failures++;
                end
                if (o_result_index !== head_result.index) begin
                    $display("%0t: result_index mismatch, expected %0d, got %0d",
                             $time, head_result.index, o_result_index);
                    failures++;
                end
                if (o_woken_pid !== head_result.woken) begin
                    $display("%0t: woken_pid mismatch, expected 0x%02h, got 0x%02h",
                             $time, head_result.woken, o_woken_pid);
                    failures++;
                end
            end
        end
    end

    initial begin
        t_script_row script [23];
        int unsigned pick;
        int unsigned waiters;
        logic [3:0]  idx;
        logic [7:0]  pid;
        logic        saturated;

        for (int i = 0; i < LOCKS; i++) begin
            mx_key[i] = '0;
            mx_handles[i] = '0;
            mx_locked[i] = 1'b0;
            mx_owner[i] = '0;
            mx_head[i] = '0;
            mx_wait_len[i] = '0;
        end
        requests_sent = 0;
        results_checked = 0;
        failures = 0;
        saturated = 1'b0;
        foreach (status_tally[i]) status_tally[i] = 0;

        // mode, key, index, pid, known, {status, index, woken}
        script = '{
            // never-opened entry, self-queue of the owner, hand-off chain incl. pid 0
            '{MODE_ACQUIRE, 32'h0, 4'd0, 8'h00, 1'b1, {ST_GRANTED, 4'd0, 8'h00}},
            '{MODE_ACQUIRE, 32'h0, 4'd0, 8'hFF, 1'b1, {ST_QUEUED, 4'd0, 8'h00}},
            '{MODE_ACQUIRE, 32'h0, 4'd0, 8'h00, 1'b1, {ST_QUEUED, 4'd0, 8'h00}},
            '{MODE_RELEASE, 32'h0, 4'd0, 8'hFF, 1'b1, {ST_NOT_OWNER, 4'd0, 8'h00}},
            '{MODE_RELEASE, 32'h0, 4'd0, 8'h00, 1'b1, {ST_HANDED, 4'd0, 8'hFF}},
            '{MODE_RELEASE, 32'h0, 4'd0, 8'hFF, 1'b1, {ST_HANDED, 4'd0, 8'h00}},
            '{MODE_RELEASE, 32'h0, 4'd0, 8'h00, 1'b1, {ST_UNLOCKED, 4'd0, 8'h00}},
            '{MODE_RELEASE, 32'h0, 4'd0, 8'h00, 1'b1, {ST_NOT_OWNER, 4'd0, 8'h00}},
            // key extremes, a hit on an open entry
            '{MODE_OPEN, 32'h8000_0000, 4'd0, 8'h00, 1'b1, {ST_OPENED, 4'd0, 8'h00}},
            '{MODE_OPEN, 32'h7FFF_FFFF, 4'd0, 8'h00, 1'b1, {ST_OPENED, 4'd1, 8'h00}},
            '{MODE_OPEN, 32'h8000_0000, 4'd0, 8'h00, 1'b1, {ST_OPENED, 4'd0, 8'h00}},
            '{MODE_OPEN, 32'h0000_0000, 4'd0, 8'h00, 1'b1, {ST_OPENED, 4'd2, 8'h00}},
            '{MODE_OPEN, 32'hFFFF_FFFF, 4'd0, 8'h00, 1'b1, {ST_OPENED, 4'd3, 8'h00}},
            '{MODE_OPEN, 32'h7FFF_FFFF, 4'd15, 8'hFF, 1'b0, {ST_OPENED, 4'd0, 8'h00}},
            '{MODE_OPEN, 32'hA5A5_A5A5, 4'd5, 8'h11, 1'b0, {ST_OPENED, 4'd0, 8'h00}},
            // undefined mode, top index
            '{MODE_UNDEF, 32'h5555_5555, 4'd15, 8'hAA, 1'b1, {ST_NOT_OWNER, 4'd15, 8'h00}},
            '{MODE_ACQUIRE, 32'h0, 4'd15, 8'hA5, 1'b1, {ST_GRANTED, 4'd15, 8'h00}},
            '{MODE_ACQUIRE, 32'h0, 4'd15, 8'h5A, 1'b0, {ST_OPENED, 4'd0, 8'h00}},
            '{MODE_RELEASE, 32'h0, 4'd15, 8'h5A, 1'b0, {ST_OPENED, 4'd0, 8'h00}},
            '{MODE_RELEASE, 32'h0, 4'd15, 8'hA5, 1'b0, {ST_OPENED, 4'd0, 8'h00}},
            '{MODE_RELEASE, 32'h0, 4'd15, 8'h5A, 1'b0, {ST_OPENED, 4'd0, 8'h00}},
            '{MODE_UNDEF, 32'hFFFF_FFFF, 4'd0, 8'h00, 1'b1, {ST_NOT_OWNER, 4'd0, 8'h00}},
            '{MODE_ACQUIRE, 32'h0, 4'd9, 8'h3C, 1'b0, {ST_OPENED, 4'd0, 8'h00}}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i])
            issue_request(script[i].mode, script[i].key, script[i].idx, script[i].pid,
                          script[i].known, script[i].want);

        while (requests_sent < RAND_ITEMS + 20) begin
            pick = $urandom_range(0, 99);
            if (!saturated && requests_sent >= 300) begin
                // push one handle count past its ceiling
                saturated = 1'b1;
                repeat (260) issue_random(MODE_OPEN, 32'h8000_0000, 4'($urandom), 8'($urandom));
            end else if (pick < 12) begin
                // opens: mostly fresh keys until the table fills, some repeats
                repeat ($urandom_range(1, 4)) begin
                    idx = 4'($urandom);
                    if ($urandom_range(0, 2) == 0 && mx_handles[idx] != 0)
                        issue_random(MODE_OPEN, mx_key[idx], 4'($urandom), 8'($urandom));
                    else
                        issue_random(MODE_OPEN, $urandom, 4'($urandom), 8'($urandom));
                end
            end else if (pick < 70) begin
                // lock, pile up waiters (sometimes past the queue depth), then hand off
                idx = 4'($urandom);
                if (!mx_locked[idx]) issue_random(MODE_ACQUIRE, $urandom, idx, 8'($urandom));
                waiters = $urandom_range(0, 18);
                repeat (waiters) begin
                    pid = ($urandom_range(0, 7) == 0) ? mx_owner[idx] : 8'($urandom);
                    issue_random(MODE_ACQUIRE, $urandom, idx, pid);
                end
                if ($urandom_range(0, 3) == 0)
                    issue_random(MODE_RELEASE, $urandom, idx,
                                 mx_owner[idx] + 8'($urandom_range(1, 255)));
                if ($urandom_range(0, 4) != 0) begin
                    while (mx_locked[idx])
                        issue_random(MODE_RELEASE, $urandom, idx, mx_owner[idx]);
                end else begin
                    repeat ($urandom_range(0, 3))
                        if (mx_locked[idx])
                            issue_random(MODE_RELEASE, $urandom, idx, mx_owner[idx]);
                end
            end else if (pick < 90) begin
                // unconstrained noise
                issue_random(2'($urandom), $urandom, 4'($urandom), 8'($urandom));
            end else begin
                // broken sequences: stray releases and undefined requests
                if ($urandom_range(0, 1) == 0)
                    issue_random(MODE_RELEASE, $urandom, 4'($urandom), 8'($urandom));
                else
                    issue_random(MODE_UNDEF, $urandom, 4'($urandom), 8'($urandom));
            end
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LOCKS + 8) @(posedge i_clk);

        $display("Checked %0d results from %0d requests across open, acquire and release.",
                 results_checked, requests_sent);
        $display("Outcomes seen: opened %0d granted %0d queued %0d handed %0d unlocked %0d",
                 status_tally[ST_OPENED], status_tally[ST_GRANTED], status_tally[ST_QUEUED],
                 status_tally[ST_HANDED], status_tally[ST_UNLOCKED]);
        $display("  table-full %0d not-owner %0d queue-full %0d; %0d failures",
                 status_tally[ST_FULL], status_tally[ST_NOT_OWNER], status_tally[ST_QFULL],
                 failures);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
